[hw/rtl/imufs_pkg.sv]
package imufs_pkg;

    typedef logic [5:0] pos_t;

    localparam pos_t PosSyncFirst  = 6'd0;
    localparam pos_t PosSyncSecond = 6'd1;
    localparam pos_t PosMsgId      = 6'd2;
    localparam pos_t PosLenLo      = 6'd3;
    localparam pos_t PosLenHi      = 6'd4;
    localparam pos_t PosPayFirst   = 6'd5;
    localparam pos_t PosPayLast    = 6'd36;
    localparam pos_t PosSumA       = 6'd37;
    localparam pos_t PosSumB       = 6'd38;

    localparam logic [15:0] PayloadLen = 16'd32;

    localparam int CfgIndexW = 2;
    localparam int PayloadW  = 256;

    typedef enum logic [CfgIndexW-1:0] {
        CFG_SYNC_FIRST  = 2'd0,
        CFG_SYNC_SECOND = 2'd1,
        CFG_MESSAGE_ID  = 2'd2
    } cfg_index_t;

    localparam logic [7:0] SyncFirstReset  = 8'd181;
    localparam logic [7:0] SyncSecondReset = 8'd98;
    localparam logic [7:0] MessageIdReset  = 8'd1;

    typedef enum logic {
        ST_IDLE,
        ST_SEND
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic emit;
        pos_t pos;
    } dp_cmd_t;

endpackage

[hw/rtl/imufs_if.sv]
interface imufs_sample_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] accel_x;
    logic signed [31:0] accel_y;
    logic signed [31:0] accel_z;
    logic signed [31:0] gyro_x;
    logic signed [31:0] gyro_y;
    logic signed [31:0] gyro_z;
    logic [63:0]        time_stamp;

    modport source (
        output valid, accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z, time_stamp,
        input  ready
    );
    modport sink (
        input  valid, accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z, time_stamp,
        output ready
    );
endinterface

interface imufs_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] frame_byte;
    logic       last_byte;

    modport source (
        output valid, frame_byte, last_byte,
        input  ready
    );
    modport sink (
        input  valid, frame_byte, last_byte,
        output ready
    );
endinterface

interface imufs_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [imufs_pkg::CfgIndexW-1:0] reg_index;
    logic [7:0]                     wr_data;

    modport source (
        output valid, reg_index, wr_data,
        input  ready
    );
    modport sink (
        input  valid, reg_index, wr_data,
        output ready
    );
endinterface

[hw/rtl/imufs_ctrl.sv]
module imufs_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    output logic                out_valid,
    input  logic                out_ready,
    output imufs_pkg::dp_cmd_t  cmd
);

    imufs_pkg::state_t state_reg, state_next;
    imufs_pkg::pos_t   pos_reg, pos_next;
    logic              out_valid_reg, out_valid_next;
    logic              advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= imufs_pkg::ST_IDLE;
            pos_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pos_reg       <= pos_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        pos_next   = pos_reg;
        in_ready   = 1'b0;
        advance    = 1'b0;
        case (state_reg)
            imufs_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                pos_next = '0;
                if (in_valid)
                begin
                    state_next = imufs_pkg::ST_SEND;
                end
            end
            imufs_pkg::ST_SEND:
            begin
                // The output register takes a new byte when it is empty or being drained.
                advance = !out_valid_reg || out_ready;
                if (advance)
                begin
                    if (pos_reg == imufs_pkg::PosSumB)
                    begin
                        // The next sample may be transferred while the last byte is loaded.
                        in_ready = 1'b1;
                        pos_next = '0;
                        if (!in_valid)
                        begin
                            state_next = imufs_pkg::ST_IDLE;
                        end
                    end
                    else
                    begin
                        pos_next = pos_reg + 6'd1;
                    end
                end
            end
            default:
            begin
                state_next = imufs_pkg::ST_IDLE;
                pos_next   = '0;
            end
        endcase

        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end

        cmd.load = in_ready && in_valid;
        cmd.emit = advance;
        cmd.pos  = pos_reg;
    end

    assign out_valid = out_valid_reg;

endmodule

[hw/rtl/imufs_dp.sv]
module imufs_dp (
    input  logic                               clk,
    input  logic                               rst_n,
    input  imufs_pkg::dp_cmd_t                 cmd,
    input  logic [imufs_pkg::PayloadW-1:0]     sample_bits,
    input  logic                               cfg_we,
    input  logic [imufs_pkg::CfgIndexW-1:0]    cfg_index,
    input  logic [7:0]                         cfg_data,
    output logic [7:0]                         frame_byte,
    output logic                               last_byte
);

    logic [7:0]                     sync_first_reg;
    logic [7:0]                     sync_second_reg;
    logic [7:0]                     message_id_reg;
    logic [imufs_pkg::PayloadW-1:0] payload_reg, payload_next;
    logic [7:0]                     sum_a_reg, sum_a_next;
    logic [7:0]                     sum_b_reg, sum_b_next;
    logic [7:0]                     byte_reg, byte_next;
    logic                           last_reg, last_next;
    logic [7:0]                     body;
    logic                           in_sum;
    logic                           in_payload;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sync_first_reg  <= imufs_pkg::SyncFirstReset;
            sync_second_reg <= imufs_pkg::SyncSecondReset;
            message_id_reg  <= imufs_pkg::MessageIdReset;
            sum_a_reg       <= '0;
            sum_b_reg       <= '0;
        end
        else
        begin
            sum_a_reg <= sum_a_next;
            sum_b_reg <= sum_b_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    imufs_pkg::CFG_SYNC_FIRST:  sync_first_reg  <= cfg_data;
                    imufs_pkg::CFG_SYNC_SECOND: sync_second_reg <= cfg_data;
                    imufs_pkg::CFG_MESSAGE_ID:  message_id_reg  <= cfg_data;
                    default:                    ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        payload_reg <= payload_next;
        byte_reg    <= byte_next;
        last_reg    <= last_next;
    end

    always_comb
    begin
        in_payload = cmd.pos inside {[imufs_pkg::PosPayFirst:imufs_pkg::PosPayLast]};
        in_sum     = cmd.pos inside {[imufs_pkg::PosMsgId:imufs_pkg::PosPayLast]};

        if (cmd.pos == imufs_pkg::PosSyncFirst)
        begin
            body = sync_first_reg;
        end
        else if (cmd.pos == imufs_pkg::PosSyncSecond)
        begin
            body = sync_second_reg;
        end
        else if (cmd.pos == imufs_pkg::PosMsgId)
        begin
            body = message_id_reg;
        end
        else if (cmd.pos == imufs_pkg::PosLenLo)
        begin
            body = imufs_pkg::PayloadLen[7:0];
        end
        else if (cmd.pos == imufs_pkg::PosLenHi)
        begin
            body = imufs_pkg::PayloadLen[15:8];
        end
        else if (cmd.pos == imufs_pkg::PosSumA)
        begin
            body = sum_a_reg;
        end
        else if (cmd.pos == imufs_pkg::PosSumB)
        begin
            body = sum_b_reg;
        end
        else
        begin
            // Payload bytes leave from the bottom of the shift line.
            body = payload_reg[7:0];
        end

        payload_next = payload_reg;
        sum_a_next   = sum_a_reg;
        sum_b_next   = sum_b_reg;
        byte_next    = byte_reg;
        last_next    = last_reg;

        if (cmd.emit)
        begin
            byte_next = body;
            last_next = (cmd.pos == imufs_pkg::PosSumB);
            if (in_payload)
            begin
                payload_next = {8'd0, payload_reg[imufs_pkg::PayloadW-1:8]};
            end
            if (in_sum)
            begin
                sum_a_next = sum_a_reg + body;
                sum_b_next = sum_b_reg + sum_a_reg + body;
            end
        end

        // A new sample only arrives on the cycle the final checksum byte is loaded, or when idle.
        if (cmd.load)
        begin
            payload_next = sample_bits;
            sum_a_next   = '0;
            sum_b_next   = '0;
        end
    end

    assign frame_byte = byte_reg;
    assign last_byte  = last_reg;

endmodule

[hw/rtl/imu_sample_frame_serializer_top.sv]
// After the sample transfer, the state and position registers step to the first byte,
// which the output register then offers. Each sample yields 39 byte transfers, one per
// cycle while the byte sink stays ready, from a single output register. The next sample
// is taken in the cycle the final checksum byte is loaded.
// Reset clears the controller, the checksum sums and sets the sync and id registers.
module imu_sample_frame_serializer_top (
    input  logic                 clk,
    input  logic                 rst_n,
    imufs_sample_if.sink         sample,
    imufs_byte_if.source         frame,
    imufs_cfg_if.sink            cfg
);

    imufs_pkg::dp_cmd_t             cmd;
    logic [imufs_pkg::PayloadW-1:0] sample_bits;

    // Axis words sit little-endian from the bottom, the timestamp on top.
    assign sample_bits = {sample.time_stamp, sample.gyro_z, sample.gyro_y, sample.gyro_x,
                          sample.accel_z, sample.accel_y, sample.accel_x};

    assign cfg.ready = 1'b1;

    imufs_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (sample.valid),
        .in_ready  (sample.ready),
        .out_valid (frame.valid),
        .out_ready (frame.ready),
        .cmd       (cmd)
    );

    imufs_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .sample_bits (sample_bits),
        .cfg_we      (cfg.valid),
        .cfg_index   (cfg.reg_index),
        .cfg_data    (cfg.wr_data),
        .frame_byte  (frame.frame_byte),
        .last_byte   (frame.last_byte)
    );

endmodule
